FILE: rtl/tlc_pkg.sv
// Package for the time curve lookup block: sizes, codes and divider bundles.
// Used by the top level, the divider and the checker.
package tlc_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = 11;
    localparam int DIV_DW = 65;
    localparam int DIV_VW = 33;
    localparam int CNTW = $clog2(DIV_DW + 1);

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic {
        CFG_NUM_POINTS = 1'b0,
        CFG_INTERVAL   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_VW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quo;
        logic [DIV_VW-1:0] rem;
    } t_div_rsp;

endpackage

FILE: rtl/tlc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tlc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/tlc_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on tlc_pkg.
module tlc_div
    import tlc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_DW-1:0] r_quo;
    logic [DIV_VW:0]   r_rem;
    logic [DIV_VW-1:0] r_dv;
    logic [CNTW-1:0]   r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_VW+1:0] sh;
    logic [DIV_VW+1:0] diff;

    assign sh   = {r_rem, r_quo[DIV_DW-1]};
    assign diff = sh - {2'b00, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_quo  <= i_req.dividend;
                r_rem  <= '0;
                r_dv   <= i_req.divisor;
                r_cnt  <= CNTW'(DIV_DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!diff[DIV_VW+1]) begin
                    r_rem <= diff[DIV_VW:0];
                    r_quo <= {r_quo[DIV_DW-2:0], 1'b1};
                end else begin
                    r_rem <= sh[DIV_VW:0];
                    r_quo <= {r_quo[DIV_DW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem[DIV_VW-1:0];

endmodule

FILE: rtl/time_curve_lookup_interpolate.sv
// Usage: a point table is loaded by write transfers on the slave stream and
// read back by query transfers, each query giving one transfer on the master
// stream. tuser[0] on the slave side selects write (0) or query (1).
// Configuration registers (point count, fixed interval) are written on the
// cfg channel, which is always ready; write them only while the block is idle.
// A write transfer is stored when it is accepted and the block is ready again
// next cycle. A query holds tready low until it is finished: fixed-interval
// mode costs one division, plus a second one when the index wraps, plus a
// table read. Variable mode costs an optional modulo, then a read and compare
// of each table entry scanned from the cursor, plus a multiply and a division
// when interpolating. The shared divider and the single RAM read port set
// these costs. The result sits in an output register; a stalled receiver
// holds it and the block may take further transfers, but the next result
// waits for it. Reset idles the block, sets the point count to 0, the
// interval to 65536 and the cursor to 1, and drops the output valid; the
// table holds no valid data until written. Reset is synchronous and active low.
// Depends on tlc_pkg, tlc_ram and tlc_div.
module time_curve_lookup_interpolate
    import tlc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_index[10:0], point_hour[42:11], point_value[74:43],
    // query_hour[106:75], zero fill
    input  logic [111:0] s_axis_tdata,
    // cmd[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // curve_value[31:0]
    output logic [31:0]  m_axis_tdata,
    // was_interpolated[0]
    output logic [0:0]   m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_WAIT, S_VAL, S_FDIV, S_FMOD, S_LAST, S_QMOD, S_CUR,
        S_NEXT, S_CMP, S_MUL, S_ISTART, S_IDIV, S_DONE
    } t_state;

    t_state r_state, r_ret;
    logic [NW-1:0]     r_num_points;
    logic [31:0]       r_interval;
    logic [NW-1:0]     r_cursor;
    logic [NW-1:0]     r_c;
    logic [NW-1:0]     r_i;
    logic [31:0]       r_q;
    logic [AW-1:0]     r_addr;
    logic [31:0]       r_last_v;
    logic [31:0]       r_prev_h;
    logic [31:0]       r_prev_v;
    logic [31:0]       r_den;
    logic [31:0]       r_mdv;
    logic [31:0]       r_mdh;
    logic              r_neg;
    logic [63:0]       r_prod;
    logic [31:0]       r_res;
    logic              r_flag;
    logic              r_out_valid;
    logic [31:0]       r_out_data;
    logic              r_out_flag;
    t_div_req          r_div;
    t_div_rsp          div_rsp;

    logic [NW-1:0]     n;
    logic              in_acc;
    logic [NW-1:0]     in_idx;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [63:0]       wr_data;
    logic [63:0]       rd_data;
    logic [31:0]       rd_h;
    logic [31:0]       rd_v;
    logic [NW-1:0]     c_sel;
    logic [32:0]       dv;
    logic [32:0]       dh;
    logic [33:0]       quo_c;
    logic [34:0]       sum;

    assign n      = (r_num_points > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : r_num_points;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign in_idx = s_axis_tdata[10:0];
    assign wr_en  = in_acc && (t_cmd'(s_axis_tuser[0]) == CMD_WRITE)
                    && (in_idx != '0) && (in_idx <= NW'(MAX_POINTS));
    assign wr_addr = AW'(in_idx - 1'b1);
    assign wr_data = {s_axis_tdata[42:11], s_axis_tdata[74:43]};
    assign rd_h    = rd_data[63:32];
    assign rd_v    = rd_data[31:0];
    assign c_sel   = (r_cursor == '0 || r_cursor > n) ? NW'(1) : r_cursor;
    assign dv      = {rd_v[31], rd_v} - {r_prev_v[31], r_prev_v};
    assign dh      = {1'b0, r_q} - {1'b0, r_prev_h};
    assign quo_c   = (div_rsp.quo > 65'(34'h2_0000_0000)) ? 34'h2_0000_0000
                                                          : div_rsp.quo[33:0];
    assign sum     = r_neg ? ({{3{r_prev_v[31]}}, r_prev_v} - {1'b0, quo_c})
                           : ({{3{r_prev_v[31]}}, r_prev_v} + {1'b0, quo_c});

    tlc_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    tlc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ret        <= S_IDLE;
            r_num_points <= '0;
            r_interval   <= 32'd65536;
            r_cursor     <= NW'(1);
            r_out_valid  <= 1'b0;
            r_div.start  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_NUM_POINTS: r_num_points <= i_cfg_data[NW-1:0];
                    CFG_INTERVAL:   r_interval   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && t_cmd'(s_axis_tuser[0]) == CMD_QUERY) begin
                        r_q    <= s_axis_tdata[106:75];
                        r_flag <= 1'b0;
                        if (n == '0) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else if (n == NW'(1)) begin
                            r_addr  <= '0;
                            r_ret   <= S_VAL;
                            r_state <= S_WAIT;
                        end else if (r_interval != '0) begin
                            r_div.start    <= 1'b1;
                            r_div.dividend <= DIV_DW'({s_axis_tdata[106:75], 1'b0})
                                              + DIV_DW'(r_interval);
                            r_div.divisor  <= {r_interval, 1'b0};
                            r_state        <= S_FDIV;
                        end else begin
                            r_addr  <= AW'(n - 1'b1);
                            r_ret   <= S_LAST;
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_WAIT: r_state <= r_ret;
                S_VAL: begin
                    r_res   <= rd_v;
                    r_state <= S_DONE;
                end
                S_FDIV: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quo > DIV_DW'(n)) begin
                            r_div.start    <= 1'b1;
                            r_div.dividend <= div_rsp.quo;
                            r_div.divisor  <= DIV_VW'(n);
                            r_state        <= S_FMOD;
                        end else begin
                            r_addr  <= (div_rsp.quo == '0) ? AW'(n - 1'b1)
                                                           : AW'(div_rsp.quo - 1'b1);
                            r_ret   <= S_VAL;
                            r_state <= S_WAIT;
                        end
                    end else begin
                        r_div.start <= 1'b0;
                    end
                end
                S_FMOD: begin
                    if (div_rsp.done) begin
                        r_addr  <= (div_rsp.rem == '0) ? AW'(n - 1'b1)
                                                       : AW'(div_rsp.rem - 1'b1);
                        r_ret   <= S_VAL;
                        r_state <= S_WAIT;
                    end else begin
                        r_div.start <= 1'b0;
                    end
                end
                S_LAST: begin
                    r_last_v <= rd_v;
                    if (r_q > rd_h && rd_h != '0) begin
                        r_div.start    <= 1'b1;
                        r_div.dividend <= DIV_DW'(r_q);
                        r_div.divisor  <= DIV_VW'(rd_h);
                        r_state        <= S_QMOD;
                    end else begin
                        if (r_q > rd_h) begin
                            r_q <= '0;
                        end
                        r_c     <= c_sel;
                        r_addr  <= AW'(c_sel - 1'b1);
                        r_ret   <= S_CUR;
                        r_state <= S_WAIT;
                    end
                end
                S_QMOD: begin
                    if (div_rsp.done) begin
                        r_q     <= div_rsp.rem[31:0];
                        r_c     <= c_sel;
                        r_addr  <= AW'(c_sel - 1'b1);
                        r_ret   <= S_CUR;
                        r_state <= S_WAIT;
                    end else begin
                        r_div.start <= 1'b0;
                    end
                end
                S_CUR: begin
                    if (rd_h > r_q && r_c != NW'(1)) begin
                        r_c     <= NW'(1);
                        r_addr  <= '0;
                        r_ret   <= S_CUR;
                        r_state <= S_WAIT;
                    end else begin
                        r_prev_h <= rd_h;
                        r_prev_v <= rd_v;
                        r_i      <= r_c + 1'b1;
                        r_state  <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_i > n) begin
                        r_cursor <= n - 1'b1;
                        r_res    <= r_last_v;
                        r_state  <= S_DONE;
                    end else begin
                        r_addr  <= AW'(r_i - 1'b1);
                        r_ret   <= S_CMP;
                        r_state <= S_WAIT;
                    end
                end
                S_CMP: begin
                    if (rd_h == r_q) begin
                        r_res    <= rd_v;
                        r_cursor <= r_i;
                        r_state  <= S_DONE;
                    end else if (rd_h > r_q) begin
                        r_cursor <= r_i - 1'b1;
                        r_flag   <= 1'b1;
                        if (rd_h <= r_prev_h) begin
                            r_res   <= r_prev_v;
                            r_state <= S_DONE;
                        end else begin
                            r_den   <= rd_h - r_prev_h;
                            r_neg   <= dv[32] ^ dh[32];
                            r_mdv   <= dv[32] ? 32'(-dv) : dv[31:0];
                            r_mdh   <= dh[32] ? 32'(-dh) : dh[31:0];
                            r_state <= S_MUL;
                        end
                    end else begin
                        r_prev_h <= rd_h;
                        r_prev_v <= rd_v;
                        r_i      <= r_i + 1'b1;
                        r_state  <= S_NEXT;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_mdv * r_mdh;
                    r_state <= S_ISTART;
                end
                S_ISTART: begin
                    r_div.start    <= 1'b1;
                    r_div.dividend <= DIV_DW'(r_prod) + DIV_DW'(r_den[31:1]);
                    r_div.divisor  <= DIV_VW'(r_den);
                    r_state        <= S_IDIV;
                end
                S_IDIV: begin
                    if (div_rsp.done) begin
                        if ($signed(sum) > $signed(35'sh0_7FFF_FFFF)) begin
                            r_res <= 32'h7FFF_FFFF;
                        end else if ($signed(sum) < -$signed(35'sh0_8000_0000)) begin
                            r_res <= 32'h8000_0000;
                        end else begin
                            r_res <= sum[31:0];
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_div.start <= 1'b0;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_out_flag  <= r_flag;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready   = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_flag;

endmodule

FILE: rtl/tlc_checker.sv
// Port-level checker for the time curve lookup block, bound to the top level.
// Depends on tlc_pkg.
module tlc_checker
    import tlc_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [0:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [31:0]  m_axis_tdata
);

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_QUERY
        |=> !s_axis_tready)
        else $error("Block stayed ready after a query transfer.");

    a_write_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == CMD_WRITE
        |=> s_axis_tready)
        else $error("Block not ready after a write transfer.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Stalled result changed.");

    a_out_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("Result appeared without a query in progress.");

endmodule

bind time_curve_lookup_interpolate tlc_checker u_tlc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
